/* rtl/core/cst_pkg.sv */
// cst_pkg: shared types and constants for the contrast stretch core
// no dependencies; used by cst_div, contrast_stretch_core, stretch_checker and tb
package cst_pkg;

    localparam int PIX_W = 8;
    localparam int CNT_W = $clog2(PIX_W);

    localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

    localparam logic OP_GATHER = 1'b0;
    localparam logic OP_MAP    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MAP
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* rtl/core/cst_div.sv */
// cst_div: restoring divider, FULL_SCALE / divisor, one quotient bit per cycle
// depends on cst_pkg
module cst_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [cst_pkg::PIX_W-1:0] divisor,
    output cst_pkg::div_status_t      status,
    output logic [cst_pkg::PIX_W-1:0] quotient
);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [cst_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [cst_pkg::PIX_W-1:0] rem_reg, rem_next;
    logic [cst_pkg::PIX_W-1:0] quo_reg, quo_next;
    logic [cst_pkg::PIX_W-1:0] den_reg, den_next;
    logic [cst_pkg::PIX_W:0]   shifted;
    logic [cst_pkg::PIX_W:0]   diff;
    logic                      fits;

    always_comb begin
        shifted = {rem_reg, cst_pkg::FULL_SCALE[cnt_reg]};
        diff    = shifted - {1'b0, den_reg};
        fits    = (shifted >= {1'b0, den_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = cst_pkg::CNT_W'(cst_pkg::PIX_W - 1);
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[cst_pkg::PIX_W-1:0] : shifted[cst_pkg::PIX_W-1:0];
            quo_next = {quo_reg[cst_pkg::PIX_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

/* rtl/core/contrast_stretch_core.sv */
// contrast_stretch_core: running min/max gather and contrast stretch map of 8-bit pixels
// gather word: updates min/max and invalidates the factor cache, no result
// map word with cached factor or flat range: ST_MAP, result registered when output free
// otherwise ST_DIV runs the bit-serial factor divider first; s_ready high only in ST_IDLE
// aresetn synchronous, active low: min 255, max 0, factor cache invalid, no result pending
// depends on cst_pkg and cst_div
module contrast_stretch_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_op,
    input  logic [cst_pkg::PIX_W-1:0] s_pixel,
    input  logic                      s_frame_start,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [cst_pkg::PIX_W-1:0] m_stretched
);

    cst_pkg::state_t           state_reg, state_next;
    logic [cst_pkg::PIX_W-1:0] min_reg, min_next;
    logic [cst_pkg::PIX_W-1:0] max_reg, max_next;
    logic [cst_pkg::PIX_W-1:0] factor_reg, factor_next;
    logic                      factor_ok_reg, factor_ok_next;
    logic [cst_pkg::PIX_W-1:0] pix_reg, pix_next;
    logic                      m_valid_reg, m_valid_next;
    logic [cst_pkg::PIX_W-1:0] m_stretched_reg, m_stretched_next;

    logic                      accept;
    logic                      flat;
    logic                      out_free;
    logic                      div_start;
    logic                      load_out;
    cst_pkg::div_status_t      div_status;
    logic [cst_pkg::PIX_W-1:0] div_quo;
    logic [cst_pkg::PIX_W-1:0] span;
    logic [cst_pkg::PIX_W-1:0] clamped;
    logic [cst_pkg::PIX_W-1:0] offset;
    logic [2*cst_pkg::PIX_W-1:0] product;
    logic [cst_pkg::PIX_W-1:0] gmin, gmax;

    assign accept   = s_valid && s_ready;
    assign flat     = (max_reg <= min_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign span     = max_reg - min_reg;

    cst_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (span),
        .status   (div_status),
        .quotient (div_quo)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cst_pkg::ST_IDLE: begin
                if (accept && s_op == cst_pkg::OP_MAP) begin
                    state_next = (flat || factor_ok_reg) ? cst_pkg::ST_MAP : cst_pkg::ST_DIV;
                end
            end
            cst_pkg::ST_DIV: begin
                if (div_status.done) begin
                    state_next = cst_pkg::ST_MAP;
                end
            end
            cst_pkg::ST_MAP: begin
                if (out_free) begin
                    state_next = cst_pkg::ST_IDLE;
                end
            end
            default: state_next = cst_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            cst_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                div_start = accept && s_op == cst_pkg::OP_MAP && !flat && !factor_ok_reg;
            end
            cst_pkg::ST_DIV: begin
            end
            cst_pkg::ST_MAP: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    // clamp, offset and scale
    always_comb begin
        clamped = pix_reg;
        if (pix_reg < min_reg) begin
            clamped = min_reg;
        end
        if (pix_reg > max_reg) begin
            clamped = max_reg;
        end
        offset  = clamped - min_reg;
        product = offset * factor_reg;
    end

    always_comb begin
        gmin = s_frame_start ? cst_pkg::FULL_SCALE : min_reg;
        gmax = s_frame_start ? '0 : max_reg;
        if (s_pixel < gmin) begin
            gmin = s_pixel;
        end
        if (s_pixel > gmax) begin
            gmax = s_pixel;
        end
    end

    always_comb begin
        min_next         = min_reg;
        max_next         = max_reg;
        factor_next      = factor_reg;
        factor_ok_next   = factor_ok_reg;
        pix_next         = pix_reg;
        m_valid_next     = m_valid_reg;
        m_stretched_next = m_stretched_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            pix_next = s_pixel;
            if (s_op == cst_pkg::OP_GATHER) begin
                min_next       = gmin;
                max_next       = gmax;
                factor_ok_next = 1'b0;
            end
        end
        if (div_status.done) begin
            factor_next    = div_quo;
            factor_ok_next = 1'b1;
        end
        if (load_out) begin
            m_valid_next     = 1'b1;
            m_stretched_next = flat ? '0 : product[cst_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cst_pkg::ST_IDLE;
            min_reg       <= cst_pkg::FULL_SCALE;
            max_reg       <= '0;
            factor_ok_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            factor_ok_reg <= factor_ok_next;
            m_valid_reg   <= m_valid_next;
        end
        factor_reg      <= factor_next;
        pix_reg         <= pix_next;
        m_stretched_reg <= m_stretched_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_stretched = m_stretched_reg;

endmodule

/* test/stretch_checker.sv */
// stretch_checker: watches both channels of contrast_stretch_core, predicts each map result
// from its own running min/max and compares every result word with the oldest prediction
// depends on cst_pkg
module stretch_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      s_op,
    input  logic [cst_pkg::PIX_W-1:0] s_pixel,
    input  logic                      s_frame_start,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [cst_pkg::PIX_W-1:0] m_stretched,
    output int                        errors,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [cst_pkg::PIX_W-1:0] gather_min;
    logic [cst_pkg::PIX_W-1:0] gather_max;
    logic [cst_pkg::PIX_W-1:0] expected_stretched[$];
    int                        mismatch_count;

    function automatic logic [cst_pkg::PIX_W-1:0] stretch_value(
        input logic [cst_pkg::PIX_W-1:0] pix,
        input logic [cst_pkg::PIX_W-1:0] lo,
        input logic [cst_pkg::PIX_W-1:0] hi
    );
        logic [cst_pkg::PIX_W-1:0]   p;
        logic [cst_pkg::PIX_W-1:0]   span;
        logic [cst_pkg::PIX_W-1:0]   factor;
        logic [2*cst_pkg::PIX_W-1:0] prod;
        if (hi <= lo) begin
            return '0;
        end
        p = pix;
        if (p < lo) begin
            p = lo;
        end
        if (p > hi) begin
            p = hi;
        end
        span   = hi - lo;
        factor = cst_pkg::FULL_SCALE / span;
        prod   = (p - lo) * factor;
        return prod[cst_pkg::PIX_W-1:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            gather_min = cst_pkg::FULL_SCALE;
            gather_max = '0;
            expected_stretched.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_stretched.size() == 0) begin
                    $error("stretched: expected none, actual %0d", m_stretched);
                    mismatch_count++;
                end else if (m_stretched !== expected_stretched[0]) begin
                    $error("stretched: expected %0d, actual %0d",
                           expected_stretched[0], m_stretched);
                    mismatch_count++;
                    void'(expected_stretched.pop_front());
                end else begin
                    void'(expected_stretched.pop_front());
                end
            end
            if (s_valid && s_ready) begin
                if (s_op == cst_pkg::OP_GATHER) begin
                    if (s_frame_start) begin
                        gather_min = cst_pkg::FULL_SCALE;
                        gather_max = '0;
                    end
                    if (s_pixel < gather_min) begin
                        gather_min = s_pixel;
                    end
                    if (s_pixel > gather_max) begin
                        gather_max = s_pixel;
                    end
                end else begin
                    expected_stretched.push_back(stretch_value(s_pixel, gather_min, gather_max));
                end
            end
        end
        errors  <= mismatch_count;
        pending <= expected_stretched.size();
    end

endmodule

/* test/tb.sv */
// tb: drives gather and map words into contrast_stretch_core with random idling on both sides
// and reports the verdict; prediction and comparison live in stretch_checker
// depends on cst_pkg, contrast_stretch_core and stretch_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS     = 1450;
    localparam int CALM_TAIL = 150;
    localparam int LIMIT     = 200000;

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      s_valid       = 1'b0;
    logic                      s_op          = cst_pkg::OP_GATHER;
    logic [cst_pkg::PIX_W-1:0] s_pixel       = '0;
    logic                      s_frame_start = 1'b0;
    logic                      m_ready       = 1'b0;
    logic                      s_ready;
    logic                      m_valid;
    logic [cst_pkg::PIX_W-1:0] m_stretched;

    int errors;
    int pending;
    int cycles   = 0;
    int sent     = 0;
    int idle_pct = 25;
    int hold_m   = 0;
    bit calm     = 1'b0;

    always #2 aclk = ~aclk;

    contrast_stretch_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_pixel       (s_pixel),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_stretched   (m_stretched)
    );

    stretch_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_pixel       (s_pixel),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_stretched   (m_stretched),
        .errors        (errors),
        .pending       (pending)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side backpressure in random bursts
    always @(posedge aclk) begin
        if (hold_m > 0) begin
            m_ready <= 1'b0;
            hold_m = hold_m - 1;
        end else if (!calm && $urandom_range(99) < idle_pct) begin
            m_ready <= 1'b0;
            hold_m = $urandom_range(2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic op, input logic [cst_pkg::PIX_W-1:0] pix,
                             input logic fs);
        if (!calm && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_pixel       <= pix;
        s_frame_start <= fs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic random_frame();
        int                        lo;
        int                        hi;
        int                        span;
        int                        n_gather;
        int                        n_map;
        logic [cst_pkg::PIX_W-1:0] pix;
        if ($urandom_range(9) < 3) begin
            span = $urandom_range(3);
        end else begin
            span = $urandom_range(255);
        end
        lo       = $urandom_range(255 - span);
        hi       = lo + span;
        n_gather = $urandom_range(10, 1);
        n_map    = $urandom_range(12, 1);
        for (int i = 0; i < n_gather; i++) begin
            if (i == 0) begin
                pix = cst_pkg::PIX_W'(lo);
            end else if (i == 1) begin
                pix = cst_pkg::PIX_W'(hi);
            end else if ($urandom_range(15) == 0) begin
                pix = cst_pkg::PIX_W'($urandom_range(255));
            end else begin
                pix = cst_pkg::PIX_W'($urandom_range(hi, lo));
            end
            send_word(cst_pkg::OP_GATHER, pix, (i == 0) && ($urandom_range(19) != 0));
        end
        if ($urandom_range(11) == 0) begin
            wait_results_drained();
        end
        for (int i = 0; i < n_map; i++) begin
            if ($urandom_range(29) == 0) begin
                send_word(cst_pkg::OP_GATHER, cst_pkg::PIX_W'($urandom_range(255)),
                          1'($urandom_range(1)));
            end
            if ($urandom_range(7) == 0) begin
                pix = cst_pkg::PIX_W'($urandom_range(255));
            end else begin
                pix = cst_pkg::PIX_W'($urandom_range(hi, lo));
            end
            send_word(cst_pkg::OP_MAP, pix, $urandom_range(15) == 0);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // nothing gathered since reset, frame start on a map word
        send_word(cst_pkg::OP_MAP, 8'd0, 1'b0);
        send_word(cst_pkg::OP_MAP, 8'd255, 1'b1);
        // flat frame
        send_word(cst_pkg::OP_GATHER, 8'd100, 1'b1);
        send_word(cst_pkg::OP_MAP, 8'd100, 1'b0);
        send_word(cst_pkg::OP_MAP, 8'd0, 1'b0);
        send_word(cst_pkg::OP_MAP, 8'd255, 1'b0);
        // full range
        send_word(cst_pkg::OP_GATHER, 8'd0, 1'b1);
        send_word(cst_pkg::OP_GATHER, 8'd255, 1'b0);
        send_word(cst_pkg::OP_MAP, 8'd0, 1'b0);
        send_word(cst_pkg::OP_MAP, 8'd255, 1'b0);
        send_word(cst_pkg::OP_MAP, 8'd128, 1'b1);
        // narrow range with clamping on both ends
        send_word(cst_pkg::OP_GATHER, 8'd20, 1'b1);
        send_word(cst_pkg::OP_GATHER, 8'd10, 1'b0);
        send_word(cst_pkg::OP_GATHER, 8'd15, 1'b0);
        send_word(cst_pkg::OP_MAP, 8'd5, 1'b0);
        send_word(cst_pkg::OP_MAP, 8'd25, 1'b0);
        send_word(cst_pkg::OP_MAP, 8'd15, 1'b0);
        // span of one, largest factor
        send_word(cst_pkg::OP_GATHER, 8'd254, 1'b1);
        send_word(cst_pkg::OP_GATHER, 8'd255, 1'b0);
        send_word(cst_pkg::OP_MAP, 8'd255, 1'b0);
        send_word(cst_pkg::OP_MAP, 8'd170, 1'b0);
        // gather continues without a frame start
        send_word(cst_pkg::OP_GATHER, 8'd0, 1'b0);
        send_word(cst_pkg::OP_MAP, 8'd200, 1'b0);
        wait_results_drained();

        while (sent < ITEMS) begin
            if (sent >= ITEMS - CALM_TAIL) begin
                calm = 1'b1;
            end else if ($urandom_range(7) == 0) begin
                case ($urandom_range(2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 25;
                    default: idle_pct = 60;
                endcase
            end
            random_frame();
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/cst_pkg.sv
rtl/core/cst_div.sv
rtl/core/contrast_stretch_core.sv
test/stretch_checker.sv
test/tb.sv
